[rtl/mmul_pkg.sv]
// shared types and constants for the int8 matrix multiply block
// command and status structs between controller and datapath, item kinds,
// configuration register indexes; no dependencies
package mmul_pkg;

    // default and widest supported matrix dimension
    localparam int MAX_DIM_DEFAULT = 64;

    // fixed field widths
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int ELEM_W   = 8;
    localparam int PROD_W   = 16;
    localparam int ACC_W    = 32;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 2;

    // stream payload widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // configuration register reset value
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // item kinds carried on tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE_A = 2'd0,
        KIND_WRITE_B = 2'd1,
        KIND_COMPUTE = 2'd2,
        KIND_READ_C  = 2'd3
    } t_kind;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT   = 2'd0,
        CFG_COL_COUNT   = 2'd1,
        CFG_INNER_COUNT = 2'd2
    } t_cfg_index;

    // controller to datapath commands
    typedef struct packed {
        logic wr_a;       // write element into A at row/col select
        logic wr_b;       // write element into B at row/col select
        logic rd_c;       // read C at row/col select
        logic rd_zero;    // the read returns zero instead of the C entry
        logic mac_valid;  // issue one multiply-accumulate term
        logic mac_first;  // first term of a dot product
        logic mac_last;   // last term of a dot product, write C after it
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] q_cnt;    // results held in the output queue
        logic       rd_pend;  // C read data arrives this cycle
        logic       pop;      // output transaction completes this cycle
        logic       mac_busy; // multiply-accumulate pipeline holds terms
    } t_dp_status;

endpackage

[rtl/mmul_ctrl.sv]
// controller of the int8 matrix multiply block: configuration registers,
// input handshake, compute sequencer over row, column and inner indexes
// depends on mmul_pkg
module mmul_ctrl #(
    parameter int MAX_DIM = mmul_pkg::MAX_DIM_DEFAULT,
    parameter int IDX_W   = $clog2(MAX_DIM)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic [mmul_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mmul_pkg::CFG_W-1:0]    i_cfg_data,
    // input item handshake and addressing fields
    input  logic                          i_s_valid,
    output logic                          o_s_ready,
    input  logic [mmul_pkg::KIND_W-1:0]   i_kind,
    input  logic [mmul_pkg::INDEX_W-1:0]  i_row_index,
    input  logic [mmul_pkg::INDEX_W-1:0]  i_col_index,
    // datapath interface
    output mmul_pkg::t_dp_cmd             o_cmd,
    output logic [IDX_W-1:0]              o_row_sel,
    output logic [IDX_W-1:0]              o_col_sel,
    output logic [IDX_W-1:0]              o_mac_i,
    output logic [IDX_W-1:0]              o_mac_j,
    output logic [IDX_W-1:0]              o_mac_k,
    input  mmul_pkg::t_dp_status          i_status
);
    import mmul_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_cfg_rows, r_cfg_cols, r_cfg_inner;
    logic [CNT_W-1:0] r_rows, r_cols, r_inner, n_rows, n_cols, n_inner;
    logic [IDX_W-1:0] r_i, r_j, r_k, n_i, n_j, n_k;

    logic       accept;
    logic [2:0] occ;
    logic       room;
    logic       in_range;
    logic       i_last, j_last, k_last;

    // zero counts as one, values above the dimension count as the dimension
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return CNT_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            return CNT_W'(MAX_DIM);
        end else begin
            return CNT_W'(v);
        end
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows  <= CFG_RESET;
            r_cfg_cols  <= CFG_RESET;
            r_cfg_inner <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ROW_COUNT:   r_cfg_rows  <= i_cfg_data;
                CFG_COL_COUNT:   r_cfg_cols  <= i_cfg_data;
                CFG_INNER_COUNT: r_cfg_inner <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // room in the output queue counting a read in flight and a pop now
    assign occ  = {1'b0, i_status.q_cnt} + {2'b00, i_status.rd_pend}
                - {2'b00, i_status.pop};
    assign room = (occ < 3'd2);

    assign o_s_ready = (r_state == S_IDLE) && room;
    assign accept    = i_s_valid && o_s_ready;

    assign in_range = (int'(i_row_index) < MAX_DIM) && (int'(i_col_index) < MAX_DIM);

    assign o_row_sel = IDX_W'(i_row_index);
    assign o_col_sel = IDX_W'(i_col_index);

    // loop end detection
    assign i_last = ((CNT_W'(r_i) + CNT_W'(1)) == r_rows);
    assign j_last = ((CNT_W'(r_j) + CNT_W'(1)) == r_cols);
    assign k_last = ((CNT_W'(r_k) + CNT_W'(1)) == r_inner);

    // command decode
    always_comb begin
        o_cmd = '0;
        if (accept) begin
            case (t_kind'(i_kind))
                KIND_WRITE_A: o_cmd.wr_a = in_range;
                KIND_WRITE_B: o_cmd.wr_b = in_range;
                KIND_READ_C: begin
                    o_cmd.rd_c    = 1'b1;
                    // outside the computed region the entry reads as zero
                    o_cmd.rd_zero = !in_range
                                 || (int'(i_row_index) >= int'(r_rows))
                                 || (int'(i_col_index) >= int'(r_cols));
                end
                default: ;
            endcase
        end
        if (r_state == S_RUN) begin
            o_cmd.mac_valid = 1'b1;
            o_cmd.mac_first = (r_k == '0);
            o_cmd.mac_last  = k_last;
        end
    end

    assign o_mac_i = r_i;
    assign o_mac_j = r_j;
    assign o_mac_k = r_k;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_rows  = r_rows;
        n_cols  = r_cols;
        n_inner = r_inner;
        case (r_state)
            S_IDLE: begin
                if (accept && (t_kind'(i_kind) == KIND_COMPUTE)) begin
                    n_state = S_RUN;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_rows  = clamp_count(r_cfg_rows);
                    n_cols  = clamp_count(r_cfg_cols);
                    n_inner = clamp_count(r_cfg_inner);
                end
            end
            S_RUN: begin
                if (k_last) begin
                    n_k = '0;
                    if (j_last) begin
                        n_j = '0;
                        if (i_last) begin
                            n_state = S_DRAIN;
                        end else begin
                            n_i = r_i + IDX_W'(1);
                        end
                    end else begin
                        n_j = r_j + IDX_W'(1);
                    end
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (!i_status.mac_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_rows  <= CNT_W'(MAX_DIM);
            r_cols  <= CNT_W'(MAX_DIM);
            r_inner <= CNT_W'(MAX_DIM);
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_rows  <= n_rows;
            r_cols  <= n_cols;
            r_inner <= n_inner;
        end
    end

endmodule

[rtl/mmul_datapath.sv]
// datapath of the int8 matrix multiply block: A, B and C memories,
// pipelined multiply-accumulate unit and a two-entry result queue
// depends on mmul_pkg
module mmul_datapath #(
    parameter int MAX_DIM = mmul_pkg::MAX_DIM_DEFAULT,
    parameter int IDX_W   = $clog2(MAX_DIM)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // commands and indexes from the controller
    input  mmul_pkg::t_dp_cmd             i_cmd,
    input  logic [IDX_W-1:0]              i_row_sel,
    input  logic [IDX_W-1:0]              i_col_sel,
    input  logic [IDX_W-1:0]              i_mac_i,
    input  logic [IDX_W-1:0]              i_mac_j,
    input  logic [IDX_W-1:0]              i_mac_k,
    input  logic [mmul_pkg::ELEM_W-1:0]   i_element,
    output mmul_pkg::t_dp_status          o_status,
    // result stream
    output logic                          o_m_valid,
    input  logic                          i_m_ready,
    output logic [mmul_pkg::ACC_W-1:0]    o_m_value
);
    import mmul_pkg::*;

    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 2 ** ADDR_W;

    logic [ELEM_W-1:0] a_mem [DEPTH];
    logic [ELEM_W-1:0] b_mem [DEPTH];
    logic [ACC_W-1:0]  c_mem [DEPTH];

    logic [ADDR_W-1:0] sel_addr;
    logic [ADDR_W-1:0] a_raddr, b_raddr;

    // stage 1: operand read
    logic [ELEM_W-1:0] r_a_rdata, r_b_rdata;
    logic              r_s1_valid, r_s1_first, r_s1_last;
    logic [ADDR_W-1:0] r_s1_caddr;
    // stage 2: product
    logic signed [PROD_W-1:0] r_prod;
    logic              r_s2_valid, r_s2_first, r_s2_last;
    logic [ADDR_W-1:0] r_s2_caddr;
    // accumulator
    logic [ACC_W-1:0]  r_acc, n_acc;

    // C read path
    logic [ACC_W-1:0]  r_c_rdata;
    logic              r_rd_pend, r_rd_zero;

    // result queue
    logic [ACC_W-1:0]  r_q_data [2];
    logic              r_q_wr_ptr, r_q_rd_ptr;
    logic [1:0]        r_q_cnt, n_q_cnt;
    logic              push, pop;

    assign sel_addr = {i_row_sel, i_col_sel};
    assign a_raddr  = {i_mac_i, i_mac_k};
    assign b_raddr  = {i_mac_k, i_mac_j};

    // A and B memories: element writes, operand reads for the walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            a_mem[sel_addr] <= i_element;
        end
        if (i_cmd.wr_b) begin
            b_mem[sel_addr] <= i_element;
        end
        r_a_rdata  <= a_mem[a_raddr];
        r_b_rdata  <= b_mem[b_raddr];
        r_s1_first <= i_cmd.mac_first;
        r_s1_last  <= i_cmd.mac_last;
        r_s1_caddr <= {i_mac_i, i_mac_j};
    end

    // signed byte product
    always_ff @(posedge i_clk) begin
        r_prod     <= $signed(r_a_rdata) * $signed(r_b_rdata);
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_caddr <= r_s1_caddr;
    end

    // accumulate, restart on the first term of each dot product
    always_comb begin
        if (r_s2_first) begin
            n_acc = ACC_W'(r_prod);
        end else begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    // C memory: dot product write, element read
    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_acc <= n_acc;
            if (r_s2_last) begin
                c_mem[r_s2_caddr] <= n_acc;
            end
        end
        if (i_cmd.rd_c) begin
            r_c_rdata <= c_mem[sel_addr];
            r_rd_zero <= i_cmd.rd_zero;
        end
    end

    // pipeline and read valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_rd_pend  <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.mac_valid;
            r_s2_valid <= r_s1_valid;
            r_rd_pend  <= i_cmd.rd_c;
        end
    end

    // result queue
    assign push    = r_rd_pend;
    assign pop     = o_m_valid && i_m_ready;
    assign n_q_cnt = r_q_cnt + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_data[r_q_wr_ptr] <= r_rd_zero ? '0 : r_c_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr_ptr <= 1'b0;
            r_q_rd_ptr <= 1'b0;
            r_q_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_q_wr_ptr <= ~r_q_wr_ptr;
            end
            if (pop) begin
                r_q_rd_ptr <= ~r_q_rd_ptr;
            end
            r_q_cnt <= n_q_cnt;
        end
    end

    assign o_m_valid = (r_q_cnt != 2'd0);
    assign o_m_value = r_q_data[r_q_rd_ptr];

    // status to the controller
    assign o_status.q_cnt    = r_q_cnt;
    assign o_status.rd_pend  = r_rd_pend;
    assign o_status.pop      = pop;
    assign o_status.mac_busy = r_s1_valid || r_s2_valid;

endmodule

[rtl/int8_matrix_multiply_top.sv]
// int8 matrix multiply top level: write A/B, read C: one transaction per cycle while idle
// and the queue has room; a read result passes the C read register, then the result queue
// compute: one term per cycle through the single MAC unit
// and the one read port of A and B, then waits for the pipeline to drain
// reset (synchronous, active low) clears control and sets all counts to 64;
// the A, B and C memories hold no defined value until written
module int8_matrix_multiply_top #(
    parameter int MAX_DIM = mmul_pkg::MAX_DIM_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [mmul_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mmul_pkg::CFG_W-1:0]      i_cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mmul_pkg::S_TDATA_W-1:0]  s_tdata,  // row_index, col_index, element_data
    input  logic [mmul_pkg::KIND_W-1:0]     s_tuser,  // kind
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mmul_pkg::M_TDATA_W-1:0]  m_tdata   // product_value
);
    import mmul_pkg::*;

    localparam int IDX_W = $clog2(MAX_DIM);

    t_dp_cmd    cmd;
    t_dp_status status;

    logic [IDX_W-1:0]   row_sel, col_sel;
    logic [IDX_W-1:0]   mac_i, mac_j, mac_k;
    logic [INDEX_W-1:0] row_index, col_index;
    logic [ELEM_W-1:0]  element_data;
    logic [ACC_W-1:0]   product_value;

    // unpack input payload
    assign row_index    = s_tdata[INDEX_W-1:0];
    assign col_index    = s_tdata[2*INDEX_W-1:INDEX_W];
    assign element_data = s_tdata[2*INDEX_W+ELEM_W-1:2*INDEX_W];

    // controller
    mmul_ctrl #(
        .MAX_DIM (MAX_DIM),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_valid   (s_tvalid),
        .o_s_ready   (s_tready),
        .i_kind      (s_tuser),
        .i_row_index (row_index),
        .i_col_index (col_index),
        .o_cmd       (cmd),
        .o_row_sel   (row_sel),
        .o_col_sel   (col_sel),
        .o_mac_i     (mac_i),
        .o_mac_j     (mac_j),
        .o_mac_k     (mac_k),
        .i_status    (status)
    );

    // datapath
    mmul_datapath #(
        .MAX_DIM (MAX_DIM),
        .IDX_W   (IDX_W)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_row_sel (row_sel),
        .i_col_sel (col_sel),
        .i_mac_i   (mac_i),
        .i_mac_j   (mac_j),
        .i_mac_k   (mac_k),
        .i_element (element_data),
        .o_status  (status),
        .o_m_valid (m_tvalid),
        .i_m_ready (m_tready),
        .o_m_value (product_value)
    );

    // pack result payload
    assign m_tdata = product_value;

endmodule
